// File: hw/rtl/nur_pkg.sv
// Shared types and constants of the not-recently-used replacement block.
// Used by nur_ctrl, nur_datapath and nur_replacement_policy; depends on nothing.
package nur_pkg;

  localparam int NumBlocks = 64;
  localparam int IdxW      = $clog2(NumBlocks);
  localparam int InIdxW    = 6;
  localparam int CfgW      = 16;
  localparam int ClassW    = 3;

  // The victim search looks at this many blocks in each cycle.
  localparam int Lanes     = 8;
  localparam int LaneW     = $clog2(Lanes);
  localparam int NumChunks = (NumBlocks + Lanes - 1) / Lanes;
  localparam int ChunkW    = (NumChunks > 1) ? $clog2(NumChunks) : 1;
  localparam int SnapN     = NumChunks * Lanes;
  localparam int KeyW      = ClassW + 2;

  localparam logic [CfgW-1:0] ClearIntervalReset = CfgW'(16);

  localparam logic [1:0] OpAccess     = 2'd0;
  localparam logic [1:0] OpReplace    = 2'd1;
  localparam logic [1:0] OpInvalidate = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [InIdxW-1:0] block_index;
    logic              set_valid;
    logic              set_modified;
    logic [InIdxW-1:0] random_start;
  } in_item_t;

  typedef struct packed {
    logic [InIdxW-1:0] victim_index;
    logic              victim_was_free;
    logic [ClassW-1:0] victim_class;
  } out_item_t;

  typedef struct packed {
    logic access;
    logic inval;
    logic start;
    logic step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_chunk;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/nur_ctrl.sv
// Controller of the replacement block: decodes items and sequences the
// victim search. Depends on nur_pkg.
module nur_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          opcode_i,
  input  nur_pkg::dp_status_t status_i,
  output logic                in_ready_o,
  output nur_pkg::ctrl_cmd_t  cmd_o
);
  import nur_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SDone = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          unique case (opcode_i)
            OpAccess:     cmd_o.access = 1'b1;
            OpInvalidate: cmd_o.inval  = 1'b1;
            OpReplace: begin
              cmd_o.start = 1'b1;
              state_d     = SScan;
            end
            default: ;
          endcase
        end
      end
      SScan: begin
        cmd_o.step = 1'b1;
        if (status_i.last_chunk) state_d = SDone;
      end
      SDone: begin
        // Wait until the output register can take the result.
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan && status_i.last_chunk) |=> (state_q == SDone))
    else $error("search did not finish after the last chunk");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> status_i.out_free)
    else $error("result loaded over a pending one");

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> !in_ready_o)
    else $error("input taken during a victim search");

endmodule

// File: hw/rtl/nur_datapath.sv
// Datapath of the replacement block: block flags, access counter, interval
// register, chunked victim search and output register. Depends on nur_pkg.
module nur_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  nur_pkg::ctrl_cmd_t      cmd_i,
  input  nur_pkg::in_item_t       in_item_i,
  input  logic                    cfg_valid_i,
  input  logic [nur_pkg::CfgW-1:0] cfg_data_i,
  input  logic                    out_ready_i,
  output nur_pkg::dp_status_t     status_o,
  output logic                    out_valid_o,
  output nur_pkg::out_item_t      out_item_o
);
  import nur_pkg::*;

  logic [NumBlocks-1:0] val_q, val_d, mod_q, mod_d, ref_q, ref_d;
  logic [CfgW-1:0]      cnt_q, cnt_d, cnt_inc, interval_q;

  logic [ClassW-1:0]    snap_q [SnapN];
  logic [ClassW-1:0]    snap_d [SnapN];
  logic [ChunkW-1:0]    chunk_q;

  logic [KeyW-1:0]      best_key_q, best_key_d;
  logic [IdxW-1:0]      best_idx_q, best_idx_d;
  logic [ClassW-1:0]    best_cls_q, best_cls_d;
  logic [IdxW-1:0]      rs_idx_q;
  logic [ClassW-1:0]    rs_cls_q;
  logic                 rs_hit_q;

  logic                 out_valid_q;
  out_item_t            out_q, out_d;

  logic [IdxW+InIdxW-1:0] blk_wide, rs_wide;
  logic [IdxW-1:0]      blk_idx, rs_idx;
  logic                 blk_in_range, rs_in_range;
  logic                 do_clear;

  assign blk_wide     = {{IdxW{1'b0}}, in_item_i.block_index};
  assign blk_idx      = blk_wide[IdxW-1:0];
  assign blk_in_range = blk_wide < (IdxW+InIdxW)'(NumBlocks);
  assign rs_wide      = {{IdxW{1'b0}}, in_item_i.random_start};
  assign rs_idx       = rs_wide[IdxW-1:0];
  assign rs_in_range  = rs_wide < (IdxW+InIdxW)'(NumBlocks);

  assign cnt_inc  = cnt_q + CfgW'(1);
  assign do_clear = cnt_inc >= interval_q;

  // Flag and counter updates for access and invalidate items.
  always_comb begin
    val_d = val_q;
    mod_d = mod_q;
    ref_d = ref_q;
    cnt_d = cnt_q;
    if (cmd_i.access) begin
      if (do_clear) begin
        ref_d = '0;
        cnt_d = '0;
      end else begin
        cnt_d = cnt_inc;
      end
      if (blk_in_range) begin
        ref_d[blk_idx] = 1'b1;
        val_d[blk_idx] = in_item_i.set_valid;
        mod_d[blk_idx] = in_item_i.set_modified;
      end
    end else if (cmd_i.inval) begin
      ref_d = '0;
      cnt_d = '0;
    end
  end

  // Snapshot of the flags; each search step consumes the lowest lanes and
  // shifts the rest down. Padding entries hold the largest key and never win.
  always_comb begin
    for (int i = 0; i < SnapN; i++) snap_d[i] = snap_q[i];
    if (cmd_i.start) begin
      for (int i = 0; i < SnapN; i++) snap_d[i] = {ClassW{1'b1}};
      for (int i = 0; i < NumBlocks; i++) snap_d[i] = {ref_q[i], mod_q[i], val_q[i]};
    end else if (cmd_i.step) begin
      for (int i = 0; i < SnapN; i++) begin
        if (i + Lanes < SnapN) snap_d[i] = snap_q[i+Lanes];
        else snap_d[i] = {ClassW{1'b1}};
      end
    end
  end

  // Invalid blocks get key zero, so the first invalid block wins outright;
  // valid blocks rank by class. Strict compare keeps the lowest index on ties.
  always_comb begin
    logic [KeyW-1:0]         key;
    logic [ChunkW+LaneW-1:0] lane_idx;
    best_key_d = best_key_q;
    best_idx_d = best_idx_q;
    best_cls_d = best_cls_q;
    key        = '0;
    lane_idx   = '0;
    if (cmd_i.start) begin
      best_key_d = {1'b1, {(KeyW-1){1'b0}}};
      best_idx_d = '0;
      best_cls_d = '0;
    end else if (cmd_i.step) begin
      for (int j = 0; j < Lanes; j++) begin
        key      = snap_q[j][0] ? {2'b01, snap_q[j]} : '0;
        lane_idx = {chunk_q, LaneW'(j)};
        if (key < best_key_d) begin
          best_key_d = key;
          best_idx_d = lane_idx[IdxW-1:0];
          best_cls_d = snap_q[j];
        end
      end
    end
  end

  // Final pick: random start wins a tie at the minimum when nothing is free.
  always_comb begin
    logic                   free;
    logic                   use_rs;
    logic [IdxW-1:0]        pick;
    logic [InIdxW+IdxW-1:0] pick_wide;
    free      = (best_key_q == '0);
    use_rs    = !free && rs_hit_q && (rs_cls_q == best_cls_q);
    pick      = use_rs ? rs_idx_q : best_idx_q;
    pick_wide = {{InIdxW{1'b0}}, pick};
    out_d.victim_index    = pick_wide[InIdxW-1:0];
    out_d.victim_was_free = free;
    out_d.victim_class    = best_cls_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q       <= '0;
      mod_q       <= '0;
      ref_q       <= '0;
      cnt_q       <= '0;
      interval_q  <= ClearIntervalReset;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      val_q <= val_d;
      mod_q <= mod_d;
      ref_q <= ref_d;
      cnt_q <= cnt_d;
      if (cfg_valid_i) interval_q <= cfg_data_i;
      if (cmd_i.start) chunk_q <= '0;
      else if (cmd_i.step) chunk_q <= chunk_q + ChunkW'(1);
      if (cmd_i.load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SnapN; i++) snap_q[i] <= snap_d[i];
    best_key_q <= best_key_d;
    best_idx_q <= best_idx_d;
    best_cls_q <= best_cls_d;
    if (cmd_i.start) begin
      rs_idx_q <= rs_idx;
      rs_hit_q <= rs_in_range;
      rs_cls_q <= {ref_q[rs_idx], mod_q[rs_idx], val_q[rs_idx]};
    end
    if (cmd_i.load) out_q <= out_d;
  end

  assign status_o.last_chunk = (chunk_q == ChunkW'(NumChunks - 1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_item_o          = out_q;

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_q)
    else $error("loaded result not presented");

  a_inval_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.inval |=> (ref_q == '0 && cnt_q == '0))
    else $error("invalidate left referenced bits or count");

  a_access_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.access && blk_in_range) |=> ref_q[$past(blk_idx)])
    else $error("accessed block not marked referenced");

  a_free_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.victim_was_free) |-> !out_q.victim_class[0])
    else $error("free victim reported as valid");

endmodule

// File: hw/rtl/nur_replacement_policy.sv
// Top level of the not-recently-used replacement block.
// Instantiates nur_ctrl and nur_datapath; depends on nur_pkg.
//
//   channel   direction   handshake                  payload
//   cfg       in          cfg_valid_i / cfg_ready_o  cfg_data_i (clear interval)
//   in        in          in_valid_i / in_ready_o    in_item_i (nur_pkg::in_item_t)
//   out       out         out_valid_o / out_ready_i  out_item_o (nur_pkg::out_item_t)
//
// Access and invalidate items finish in the cycle they are accepted.
// A replace item snapshots the flags, searches, then waits for a free output
// register; the victim search walks the snapshot eight blocks a cycle.
// The next item is taken once the result sits in the output register, even
// while out_ready_i is low; a second result waits until the first is taken.
// Reset clears all flags and the counter at once; no clearing pass is needed.
module nur_replacement_policy (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [nur_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  nur_pkg::in_item_t        in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output nur_pkg::out_item_t       out_item_o
);
  import nur_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  nur_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_item_i.opcode),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  nur_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
